>>> src/mqf_pkg.sv
`default_nettype none

package mqf_pkg;

  // queue set geometry
  localparam int NUM_QUEUES  = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;

  // derived widths
  localparam int QIDX_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_SIZE = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

  // fixed field widths
  localparam int OPCODE_W = 2;
  localparam int QSEL_W   = 3;
  localparam int WORD_W   = 32;
  localparam int OCC_W    = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SIZE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // circular pointer step with wrap at the queue depth
  function automatic ptr_t ptr_advance(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/multi_queue_fifo_core.sv
// A result is registered and presented in the cycle after its item is accepted.
// Throughput: one item per cycle while the result is not stalled; the single-port
// entry store and the per-queue pointer update are done as the item is accepted.
// Reset: asynchronous, active low; all pointers and counts clear to zero,
// queues_in_use returns to 4, the entry store is not cleared.
`default_nettype none

module multi_queue_fifo_core
  import mqf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: queues_in_use
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_wdata_i,
  // input items
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] push_data
  input  wire logic [4:0]  s_axis_tuser,   // [1:0] opcode, [4:2] queue_index
  // result items
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [39:0] m_axis_tdata,   // [31:0] pop_data, [36:32] occupancy, [39:37] zero
  output      logic [1:0]  m_axis_tuser    // [1:0] status
);

  // configuration register
  logic [CFG_W-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // queue state
  ptr_t head_q [NUM_QUEUES];
  ptr_t tail_q [NUM_QUEUES];
  cnt_t cnt_q  [NUM_QUEUES];

  logic [DATA_WIDTH-1:0] store_mem [STORE_SIZE];

  // output register
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [OCC_W-1:0]      occ_q;
  logic                  pop_ok_q;
  logic [DATA_WIDTH-1:0] rd_data_q;

  // item decode
  logic                accept;
  logic [OPCODE_W-1:0] op;
  logic [QSEL_W-1:0]   qsel;
  logic [QIDX_W-1:0]   qi;
  logic                q_valid;
  ptr_t                cur_head;
  ptr_t                cur_tail;
  cnt_t                cur_cnt;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = s_axis_tuser[1:0];
  assign qsel          = s_axis_tuser[4:2];
  assign qi            = QIDX_W'(qsel);
  assign q_valid       = (32'(qsel) < 32'(cfg_q)) && (32'(qsel) < NUM_QUEUES);
  assign cur_head      = head_q[qi];
  assign cur_tail      = tail_q[qi];
  assign cur_cnt       = cnt_q[qi];

  // operation logic
  logic                do_push;
  logic                do_pop;
  logic [STATUS_W-1:0] status_d;
  cnt_t                occ_d;
  logic [ADDR_W-1:0]   addr;

  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    status_d = ST_OK;
    occ_d    = cur_cnt;
    addr     = ADDR_W'(qi) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_tail);
    if (!q_valid) begin
      status_d = ST_INVALID;
      occ_d    = '0;
    end else begin
      case (op)
        OP_PUSH: begin
          if (cur_cnt == CNT_W'(QUEUE_DEPTH)) begin
            status_d = ST_FULL;
          end else begin
            do_push = 1'b1;
            occ_d   = cur_cnt + 1'b1;
          end
        end
        OP_POP: begin
          addr = ADDR_W'(qi) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_head);
          if (cur_cnt == '0) begin
            status_d = ST_EMPTY;
          end else begin
            do_pop = 1'b1;
            occ_d  = cur_cnt - 1'b1;
          end
        end
        default: begin
          occ_d = cur_cnt;
        end
      endcase
    end
  end

  // pointer and count update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (accept) begin
      if (do_push) begin
        tail_q[qi] <= ptr_advance(cur_tail);
        cnt_q[qi]  <= occ_d;
      end
      if (do_pop) begin
        head_q[qi] <= ptr_advance(cur_head);
        cnt_q[qi]  <= occ_d;
      end
    end
  end

  // entry store, one access per item
  always_ff @(posedge clk_i) begin
    if (accept && do_push) begin
      store_mem[addr] <= s_axis_tdata[DATA_WIDTH-1:0];
    end
    if (accept && do_pop) begin
      rd_data_q <= store_mem[addr];
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      occ_q    <= OCC_W'(occ_d);
      pop_ok_q <= do_pop;
    end
  end

  logic [WORD_W-1:0] pop_word;

  assign pop_word      = pop_ok_q ? WORD_W'(rd_data_q) : '0;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, occ_q, pop_word};
  assign m_axis_tuser  = status_q;

  // a full refusal reports a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_FULL) |-> (occ_q == OCC_W'(QUEUE_DEPTH)))
    else $error("full status without full occupancy");

  // an invalid index gives zero data and zero occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_INVALID) |-> (occ_q == '0 && !pop_ok_q))
    else $error("invalid index result not cleared");

  // an empty pop gives zero data and zero occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> (occ_q == '0 && !pop_ok_q))
    else $error("empty pop result not cleared");

  // a held result keeps its payload while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
